/* rtl/core/ptt_pkg.sv */
// Shared constants, types and helper functions for the per-slot virtual tick timer.
`timescale 1ns / 1ps
package ptt_pkg;

	localparam int SLOTS    = 8;
	localparam int MAX_RATE = 1024;
	localparam int MIN_RATE = 2;

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = 10;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	localparam int OPEN_RAW = MAX_RATE / 2;
	localparam logic [CNT_W-1:0] OPEN_INTERVAL =
		CNT_W'((OPEN_RAW > CNT_MAX) ? CNT_MAX : OPEN_RAW);

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_OPEN  = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_RATE  = 3'd3;
	localparam logic [2:0] OP_POLL  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_NOT_YET = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_EXEC,
		S_RESP
	} state_t;

	// one slot as seen on the bank read port
	typedef struct packed {
		logic             enabled;
		logic [CNT_W-1:0] interval;
		logic [CNT_W-1:0] remaining;
	} slot_rd_t;

	// write command into the slot bank
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             we_en;
		logic             en_val;
		logic             we_int;
		logic [CNT_W-1:0] int_val;
		logic             we_rem;
		logic [CNT_W-1:0] rem_val;
	} slot_wr_t;

	function automatic logic rate_ok(input logic [15:0] hz);
		logic pow2;
		pow2 = (hz != 16'd0) && ((hz & (hz - 16'd1)) == 16'd0);
		return pow2 && (32'(hz) >= MIN_RATE) && (32'(hz) <= MAX_RATE);
	endfunction

	// hz is a single power of two here, so MAX_RATE/hz is a selected shift
	function automatic logic [CNT_W-1:0] rate_interval(input logic [15:0] hz);
		int acc;
		int q;
		acc = 0;
		for (int k = 0; k < 16; k++) begin
			q = MAX_RATE >> k;
			if (q > CNT_MAX) q = CNT_MAX;
			if (hz[k]) acc = acc | q;
		end
		return CNT_W'(acc);
	endfunction

endpackage

/* rtl/core/ptt_slot_bank.sv */
// Per-slot state registers: enable, interval and remaining count, one read and one write port.
`timescale 1ns / 1ps
module ptt_slot_bank
	import ptt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output slot_rd_t         rd,
	input  slot_wr_t         wr
);

	logic             enabled_q   [SLOTS];
	logic [CNT_W-1:0] interval_q  [SLOTS];
	logic [CNT_W-1:0] remaining_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				enabled_q[i]   <= 1'b0;
				interval_q[i]  <= '0;
				remaining_q[i] <= '0;
			end
		end else begin
			if (wr.we_en)  enabled_q[wr.idx]   <= wr.en_val;
			if (wr.we_int) interval_q[wr.idx]  <= wr.int_val;
			if (wr.we_rem) remaining_q[wr.idx] <= wr.rem_val;
		end
	end

	assign rd.enabled   = enabled_q[rd_idx];
	assign rd.interval  = interval_q[rd_idx];
	assign rd.remaining = remaining_q[rd_idx];

endmodule

/* rtl/core/ptt_ctrl.sv */
// Sequencer with the shared count unit: walks slots on a tick, executes slot commands.
`timescale 1ns / 1ps
module ptt_ctrl
	import ptt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       opcode,
	input  logic [2:0]       slot,
	input  logic [15:0]      hertz,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] rd_idx,
	input  slot_rd_t         rd,
	output slot_wr_t         wr
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0]       op_q;
	logic             slot_ok_q;
	logic [15:0]      hz_q;
	logic [1:0]       status_q, status_d;
	logic             accept;
	logic             rem_zero;
	logic [CNT_W-1:0] rem_dec;

	assign accept = start && (state_q == S_IDLE);

	// shared count unit: zero test and decrement of the slot under the index
	assign rem_zero = (rd.remaining == '0);
	assign rem_dec  = rd.remaining - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			slot_ok_q <= (32'(slot) < SLOTS);
			hz_q      <= hertz;
		end
		status_q <= status_d;
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		status_d   = status_q;
		wr         = '0;
		wr.idx     = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode == OP_TICK) begin
						state_d = S_TICK;
						idx_d   = '0;
					end else begin
						state_d = S_EXEC;
						idx_d   = IDX_W'(slot);
					end
				end
			end
			S_TICK: begin
				if (rd.enabled && !rem_zero) begin
					wr.we_rem  = 1'b1;
					wr.rem_val = rem_dec;
				end
				if (idx_q == LAST_IDX) begin
					state_d  = S_RESP;
					status_d = ST_OK;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_EXEC: begin
				state_d  = S_RESP;
				status_d = ST_REJECT;
				if (slot_ok_q) begin
					case (op_q)
						OP_OPEN: begin
							wr.we_en   = 1'b1;
							wr.en_val  = 1'b1;
							wr.we_int  = 1'b1;
							wr.int_val = OPEN_INTERVAL;
							wr.we_rem  = 1'b1;
							wr.rem_val = OPEN_INTERVAL;
							status_d   = ST_OK;
						end
						OP_CLOSE: begin
							wr.we_en  = 1'b1;
							wr.en_val = 1'b0;
							status_d  = ST_OK;
						end
						OP_RATE: begin
							if (rate_ok(hz_q)) begin
								wr.we_int  = 1'b1;
								wr.int_val = rate_interval(hz_q);
								status_d   = ST_OK;
							end
						end
						OP_POLL: begin
							if (!rd.enabled) begin
								status_d = ST_REJECT;
							end else if (!rem_zero) begin
								status_d = ST_NOT_YET;
							end else begin
								wr.we_rem  = 1'b1;
								wr.rem_val = rd.interval;
								status_d   = ST_OK;
							end
						end
						default: status_d = ST_REJECT;
					endcase
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rd_idx = idx_q;
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_RESP);
	assign status = status_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_REJECT || status == ST_NOT_YET))
		else $error("undefined status on result beat");

	a_tick_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && idx_q != LAST_IDX) |=>
			(state_q == S_TICK && idx_q == $past(idx_q) + IDX_W'(1)))
		else $error("tick walk skipped a slot");

	a_tick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && idx_q == LAST_IDX) |=> (done && status == ST_OK))
		else $error("tick did not end in a success beat");

endmodule

/* rtl/core/per_slot_virtual_tick_timer.sv */
// Top level of the per-slot virtual tick timer: command sequencer plus slot state bank.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------
//  command   | start / busy         | opcode[2:0] slot[2:0] hertz[15:0]
//  result    | done (one-cycle)     | status[1:0]
//
// A command beat is taken when start is high and busy is low.
// Tick walks all SLOTS slots through one shared decrementer, one slot a cycle;
// the result state then raises done, and a new command is taken once back in idle.
// Open, close, set rate and poll pass through the execute state, then the result state.
// Reset clears all slot state at once; no sweep. The receiver cannot stall.
`timescale 1ns / 1ps
module per_slot_virtual_tick_timer
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [2:0]  slot,
	input  logic [15:0] hertz,
	output logic        done,
	output logic [1:0]  status
);

	logic [IDX_W-1:0] rd_idx;
	slot_rd_t         rd;
	slot_wr_t         wr;

	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.slot   (slot),
		.hertz  (hertz),
		.busy   (busy),
		.done   (done),
		.status (status),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	ptt_slot_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

endmodule
